// ----- sv/smcp_pkg.sv -----
// Shared types and constants for the serial motor command parser.
// No dependencies; imported by smcp_split and serial_motor_command_parser.
package smcp_pkg;

  localparam int unsigned HEAD_W = 19;
  localparam int unsigned TYPE_W = 11;
  localparam int unsigned VAL_W  = 15;
  localparam int unsigned MAG_W  = 32;

  // Largest magnitude the converter holds; a negative number may reach it.
  localparam logic [MAG_W-1:0] MAG_LIMIT = 32'h8000_0000;
  localparam logic [MAG_W-1:0] POS_MAX   = 32'h7FFF_FFFF;

  // Reciprocals for exact unsigned division of a 32-bit value.
  localparam logic [31:0]     RECIP_1E4 = 32'hD1B7_1759;  // >> 45
  localparam logic [31:0]     RECIP_1E7 = 32'h6B5F_CA6B;  // >> 54
  localparam int unsigned     SHIFT_1E4 = 45;
  localparam int unsigned     SHIFT_1E7 = 54;

  localparam logic [7:0] CH_BANG  = 8'h21;  // '!'
  localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_Q     = 8'h51;
  localparam logic [7:0] CH_L     = 8'h4C;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_S    = 3'd1,
    MODE_R    = 3'd2,
    MODE_T    = 3'd3,
    MODE_P    = 3'd4,
    MODE_Q    = 3'd5,
    MODE_H    = 3'd6,
    MODE_L    = 3'd7
  } mode_e;

  typedef enum logic [1:0] {
    PH_BLANK  = 2'd0,
    PH_DIGITS = 2'd1,
    PH_STOP   = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    KIND_SPEED = 2'd0,
    KIND_FULL  = 2'd1,
    KIND_GRIP  = 2'd2
  } kind_e;

  localparam logic [1:0] MOTOR_ONE  = 2'd0;
  localparam logic [1:0] MOTOR_TWO  = 2'd1;
  localparam logic [1:0] MOTOR_BOTH = 2'd2;

  typedef struct packed {
    logic signed [HEAD_W-1:0] head;
    logic signed [TYPE_W-1:0] cmd_type;
    logic signed [VAL_W-1:0]  value;
  } split_t;

endpackage

// ----- sv/smcp_split.sv -----
// Splits a signed number (sign + magnitude) into head, type and value fields.
// Depends on smcp_pkg for field widths, reciprocals and split_t.
module smcp_split (
  input  logic [smcp_pkg::MAG_W-1:0] mag_i,
  input  logic                       neg_i,
  input  logic                       full_i,
  output smcp_pkg::split_t           split_o
);
  import smcp_pkg::*;

  logic [63:0] prod_1e4;
  logic [63:0] prod_1e7;
  logic [17:0] quot_1e4;
  logic [9:0]  quot_1e7;
  logic [17:0] type_mag;
  logic [31:0] val_mag;
  logic [17:0] head_mag;

  // Both quotients come straight from the magnitude, in parallel.
  assign prod_1e4 = 64'(mag_i) * 64'(RECIP_1E4);
  assign prod_1e7 = 64'(mag_i) * 64'(RECIP_1E7);
  assign quot_1e4 = prod_1e4[SHIFT_1E4 +: 18];
  assign quot_1e7 = prod_1e7[SHIFT_1E7 +: 10];

  assign type_mag = quot_1e4 - 18'(quot_1e7 * 18'd1000);
  assign val_mag  = mag_i - 32'(32'(quot_1e4) * 32'd10000);
  assign head_mag = full_i ? 18'(quot_1e7) : quot_1e4;

  always_comb begin
    logic signed [HEAD_W-1:0] head_s;
    logic signed [TYPE_W-1:0] type_s;
    logic signed [VAL_W-1:0]  val_s;
    head_s = HEAD_W'(head_mag);
    type_s = full_i ? TYPE_W'(type_mag[9:0]) : '0;
    val_s  = VAL_W'(val_mag[13:0]);
    // Truncating division: apply the sign after dividing the magnitude.
    split_o.head     = neg_i ? -head_s : head_s;
    split_o.cmd_type = neg_i ? -type_s : type_s;
    split_o.value    = neg_i ? -val_s  : val_s;
  end

endmodule

// ----- sv/serial_motor_command_parser.sv -----
// Serial motor command parser: the input byte register and then the result
// register lie between input beat and result beat; one beat per cycle sustained;
// both registers keep flowing as long as the output side takes results.
// Mode, number converter and byte count update in the cycle the byte leaves the
// input register; the split of the number is one pass of two 32x32 reciprocal
// multipliers. Reset (rst_ni low, asynchronous) clears mode, converter and valids.
module serial_motor_command_parser #(
  parameter int unsigned BUFFER_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream: tdata[7:0] = rx_byte
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  // Result stream: tdata[1:0] = motor_select, [20:2] = head_number,
  // [31:21] = command_type, [46:32] = value_field, [47] = gripper_level
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,
  // tuser[1:0] = kind
  output logic [1:0]  m_axis_tuser
);
  import smcp_pkg::*;

  localparam int unsigned CNT_W = $clog2(BUFFER_DEPTH + 1);

  // Input register
  logic       in_vld_q, in_vld_d;
  logic [7:0] in_byte_q;

  // Parser state
  mode_e            mode_q, mode_d;
  phase_e           phase_q, phase_d;
  logic [MAG_W-1:0] acc_q, acc_d;
  logic             neg_q, neg_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  // Result register
  logic        out_vld_q, out_vld_d;
  logic [47:0] out_data_q, out_data_d;
  logic [1:0]  out_user_q, out_user_d;

  logic  advance, proc;
  logic  is_letter;
  mode_e mode_eff;
  logic  emit_grip, emit_cmd, is_cmd_mode, feed;
  logic  is_digit, is_blank;
  logic [3:0]       digit;
  logic [35:0]      acc_mul;
  logic [MAG_W-1:0] acc_sat;
  logic [MAG_W-1:0] conv_mag;
  split_t           split;

  // The input register moves whenever the result register can take a beat.
  assign advance       = !out_vld_q || m_axis_tready;
  assign s_axis_tready = !in_vld_q || advance;
  assign proc          = in_vld_q && advance;

  // Decode a mode letter; any other byte keeps the current mode.
  always_comb begin
    is_letter = 1'b1;
    mode_eff  = mode_q;
    unique case (in_byte_q)
      CH_S:    mode_eff = MODE_S;
      CH_R:    mode_eff = MODE_R;
      CH_T:    mode_eff = MODE_T;
      CH_P:    mode_eff = MODE_P;
      CH_Q:    mode_eff = MODE_Q;
      CH_H:    mode_eff = MODE_H;
      CH_L:    mode_eff = MODE_L;
      default: is_letter = 1'b0;
    endcase
  end

  assign emit_grip   = (mode_eff == MODE_P) || (mode_eff == MODE_Q);
  assign is_cmd_mode = (mode_eff == MODE_S) || (mode_eff == MODE_R) ||
                       (mode_eff == MODE_T) || (mode_eff == MODE_H);
  assign emit_cmd    = is_cmd_mode && (in_byte_q == CH_BANG);
  // A mode letter in a command mode is always that mode's own letter: never fed.
  assign feed        = is_cmd_mode && (in_byte_q != CH_BANG) && !is_letter;

  assign is_digit = (in_byte_q >= CH_ZERO) && (in_byte_q <= CH_NINE);
  assign is_blank = (in_byte_q == CH_SPACE) ||
                    ((in_byte_q >= CH_TAB) && (in_byte_q <= CH_CR));
  assign digit    = 4'(in_byte_q - CH_ZERO);

  // acc * 10 + digit, saturated at the magnitude limit.
  assign acc_mul = (36'(acc_q) << 3) + (36'(acc_q) << 1) + 36'(digit);
  assign acc_sat = (acc_mul > 36'(MAG_LIMIT)) ? MAG_LIMIT : acc_mul[MAG_W-1:0];

  // Mode next state: take the decoded mode, drop back to idle after a command.
  always_comb begin
    mode_d = mode_q;
    if (proc) begin
      mode_d = emit_cmd ? MODE_IDLE : mode_eff;
    end
  end

  // Converter next state.
  always_comb begin
    phase_d = phase_q;
    acc_d   = acc_q;
    neg_d   = neg_q;
    cnt_d   = cnt_q;
    if (proc && emit_cmd) begin
      phase_d = PH_BLANK;
      acc_d   = '0;
      neg_d   = 1'b0;
      cnt_d   = '0;
    end else if (proc && feed && (cnt_q < CNT_W'(BUFFER_DEPTH))) begin
      cnt_d = cnt_q + CNT_W'(1);
      case (phase_q)
        PH_BLANK: begin
          if (is_blank) begin
            // skip leading white space
          end else if (in_byte_q == CH_PLUS) begin
            phase_d = PH_DIGITS;
          end else if (in_byte_q == CH_MINUS) begin
            neg_d   = 1'b1;
            phase_d = PH_DIGITS;
          end else if (is_digit) begin
            phase_d = PH_DIGITS;
            acc_d   = acc_sat;
          end else begin
            phase_d = PH_STOP;
          end
        end
        PH_DIGITS: begin
          if (is_digit) begin
            acc_d = acc_sat;
          end else begin
            phase_d = PH_STOP;
          end
        end
        default: begin
          // stopped: hold the number
        end
      endcase
    end
  end

  // Positive overflow clamps to the largest positive value.
  assign conv_mag = (!neg_q && (acc_q > POS_MAX)) ? POS_MAX : acc_q;

  smcp_split u_split (
    .mag_i   (conv_mag),
    .neg_i   (neg_q),
    .full_i  (mode_eff == MODE_H),
    .split_o (split)
  );

  // Result assembly.
  always_comb begin
    logic [1:0]               motor;
    logic signed [HEAD_W-1:0] head;
    logic signed [TYPE_W-1:0] ctype;
    logic signed [VAL_W-1:0]  value;
    logic                     grip;
    kind_e                    kind;
    motor = MOTOR_ONE;
    head  = split.head;
    ctype = split.cmd_type;
    value = split.value;
    grip  = 1'b0;
    kind  = KIND_SPEED;
    if (emit_grip) begin
      kind  = KIND_GRIP;
      head  = '0;
      ctype = '0;
      value = '0;
      grip  = (mode_eff == MODE_P);
    end else if (mode_eff == MODE_H) begin
      kind = KIND_FULL;
    end else if (mode_eff == MODE_R) begin
      motor = MOTOR_TWO;
    end else if (mode_eff == MODE_T) begin
      motor = MOTOR_BOTH;
    end
    out_data_d = {grip, value, ctype, head, motor};
    out_user_d = kind;
  end

  always_comb begin
    in_vld_d  = in_vld_q;
    out_vld_d = out_vld_q;
    if (s_axis_tready) begin
      in_vld_d = s_axis_tvalid;
    end
    if (advance) begin
      out_vld_d = proc && (emit_grip || emit_cmd);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      mode_q    <= MODE_IDLE;
      phase_q   <= PH_BLANK;
      acc_q     <= '0;
      neg_q     <= 1'b0;
      cnt_q     <= '0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      mode_q    <= mode_d;
      phase_q   <= phase_d;
      acc_q     <= acc_d;
      neg_q     <= neg_d;
      cnt_q     <= cnt_d;
    end
  end

  // Payload registers: load on accepted beats only, no reset needed.
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
    end
    if (proc) begin
      out_data_q <= out_data_d;
      out_user_q <= out_user_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule
